@@ design/i2a_pkg.sv @@
package i2a_pkg;

    localparam int I2A_QUEUE_DEPTH = 2;
    localparam int I2A_MAX_DIGITS  = 10;

    // Format selector codes.
    localparam logic [1:0] KIND_SDEC = 2'd0;
    localparam logic [1:0] KIND_UDEC = 2'd1;
    localparam logic [1:0] KIND_HEXL = 2'd2;
    localparam logic [1:0] KIND_HEXU = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;

    // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP10) >> RECIP10_SHIFT.
    localparam logic [32:0] RECIP10       = 33'h0CCCCCCCD;
    localparam int          RECIP10_SHIFT = 35;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic [3:0] char_count;
    } t_out_item;

    typedef struct packed {
        logic        neg;
        logic        dec;
        logic        upper;
        logic [31:0] mag;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_EMIT
    } t_back_state;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CHAR_ZERO + {4'b0, d};
        end else begin
            r = (upper ? CHAR_UP_A : CHAR_LOW_A) + {4'b0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

@@ design/i2a_front.sv @@
module i2a_front (
    input  logic              i_start,
    input  i2a_pkg::t_in_item i_in,
    input  i2a_pkg::t_q_stat  i_stat,
    output logic              o_busy,
    output logic              o_push,
    output i2a_pkg::t_job     o_job
);

    logic is_neg;

    assign o_busy = i_stat.full;
    assign o_push = i_start && !i_stat.full;

    // Only signed decimal treats the top bit as a sign.
    assign is_neg = (i_in.kind == i2a_pkg::KIND_SDEC) && i_in.value[31];

    always_comb begin
        o_job.neg   = is_neg;
        o_job.dec   = (i_in.kind == i2a_pkg::KIND_SDEC) || (i_in.kind == i2a_pkg::KIND_UDEC);
        o_job.upper = (i_in.kind == i2a_pkg::KIND_HEXU);
        o_job.mag   = is_neg ? (~i_in.value + 32'd1) : i_in.value;
    end

endmodule

@@ design/i2a_queue.sv @@
module i2a_queue #(
    parameter int DEPTH = i2a_pkg::I2A_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2a_pkg::t_job    i_job,
    input  logic             i_pop,
    output i2a_pkg::t_job    o_job,
    output i2a_pkg::t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2a_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (!i_push && i_pop) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full)) else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty)) else $error("pop from an empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

@@ design/i2a_back.sv @@
module i2a_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2a_pkg::t_job      i_job,
    input  i2a_pkg::t_q_stat   i_stat,
    output logic               o_pop,
    output logic               o_strobe,
    output i2a_pkg::t_out_item o_result
);

    localparam int ND = i2a_pkg::I2A_MAX_DIGITS;

    i2a_pkg::t_back_state r_state, n_state;
    logic [31:0]        r_val, n_val;
    logic               r_neg, n_neg;
    logic               r_dec, n_dec;
    logic               r_upper, n_upper;
    logic               r_sign, n_sign;
    logic [3:0]         r_nd, n_nd;
    logic [3:0]         r_left, n_left;
    logic [3:0]         r_total, n_total;
    logic [3:0]         r_dig [ND];
    logic               r_strobe, n_strobe;
    i2a_pkg::t_out_item r_out, n_out;

    logic [64:0] prod;
    logic [31:0] quot;
    logic [31:0] quot10;
    logic [31:0] rem32;
    logic [3:0]  digit;
    logic        push_dig;
    logic        shift_out;

    // One digit per cycle: divide by ten through the reciprocal, or peel a nibble.
    assign prod   = {33'b0, r_val} * {32'b0, i2a_pkg::RECIP10};
    assign quot10 = {quot[28:0], 3'b0} + {quot[30:0], 1'b0};
    assign rem32  = r_val - quot10;

    assign quot  = r_dec ? {2'b0, prod[64:i2a_pkg::RECIP10_SHIFT]} : {4'b0, r_val[31:4]};
    assign digit = r_dec ? rem32[3:0] : r_val[3:0];

    assign o_pop = !i_stat.empty
                   && ((r_state == i2a_pkg::BK_IDLE)
                       || ((r_state == i2a_pkg::BK_EMIT) && (r_left == 4'd1)));

    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_neg     = r_neg;
        n_dec     = r_dec;
        n_upper   = r_upper;
        n_sign    = r_sign;
        n_nd      = r_nd;
        n_left    = r_left;
        n_total   = r_total;
        n_strobe  = 1'b0;
        n_out     = r_out;
        push_dig  = 1'b0;
        shift_out = 1'b0;
        case (r_state)
            i2a_pkg::BK_IDLE: begin
            end
            i2a_pkg::BK_CONV: begin
                push_dig = 1'b1;
                n_val    = quot;
                n_nd     = 4'(r_nd + 4'd1);
                if (quot == 32'd0) begin
                    n_state = i2a_pkg::BK_EMIT;
                    n_left  = 4'(r_nd + 4'd1 + {3'b0, r_neg});
                    n_total = 4'(r_nd + 4'd1 + {3'b0, r_neg});
                    n_sign  = r_neg;
                end
            end
            i2a_pkg::BK_EMIT: begin
                n_strobe = 1'b1;
                if (r_sign) begin
                    n_out.character = i2a_pkg::CHAR_MINUS;
                    n_sign          = 1'b0;
                end else begin
                    n_out.character = i2a_pkg::digit_to_ascii(r_dig[0], r_upper);
                    shift_out       = 1'b1;
                end
                n_out.last       = (r_left == 4'd1);
                n_out.char_count = (r_left == 4'd1) ? r_total : 4'd0;
                n_left           = 4'(r_left - 4'd1);
                if (r_left == 4'd1) begin
                    n_state = i2a_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = i2a_pkg::BK_IDLE;
            end
        endcase
        // A new job loads here, also straight after the last beat of the previous one.
        if (o_pop) begin
            n_state = i2a_pkg::BK_CONV;
            n_val   = i_job.mag;
            n_neg   = i_job.neg;
            n_dec   = i_job.dec;
            n_upper = i_job.upper;
            n_nd    = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= i2a_pkg::BK_IDLE;
            r_strobe <= 1'b0;
            r_nd     <= 4'd0;
            r_left   <= 4'd0;
            r_sign   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_nd     <= n_nd;
            r_left   <= n_left;
            r_sign   <= n_sign;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_neg   <= n_neg;
        r_dec   <= n_dec;
        r_upper <= n_upper;
        r_total <= n_total;
        r_out   <= n_out;
    end

    // Digit stack: pushed at the bottom while converting, so the most
    // significant digit ends up at the bottom and leaves first.
    always_ff @(posedge i_clk) begin
        if (push_dig) begin
            r_dig[0] <= digit;
            for (int i = 1; i < ND; i++) begin
                r_dig[i] <= r_dig[i-1];
            end
        end else if (shift_out) begin
            for (int i = 0; i < ND - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_conv_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2a_pkg::BK_CONV) |=> !r_strobe)
        else $error("result beat produced during conversion");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2a_pkg::BK_CONV) |-> (r_nd < 4'(ND)))
        else $error("digit stack overrun");

    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.last) |-> (r_out.char_count != 4'd0))
        else $error("last beat without a character count");

endmodule

@@ design/integer_to_ascii_formatter.sv @@
// Channel  Direction  Handshake                Payload
// input    in         i_start high, o_busy low  i_in     (kind, value)
// result   out        o_strobe for one cycle    o_result (character, last, char_count)
//
// The back end converts digit by digit (a division by ten through a single
// reciprocal multiply, or a nibble shift for hex) and then emits the text
// character by character.
// A two-entry job queue lets the front take new values while the back works.
// Reset is synchronous and active low; it empties the queue and idles the back.
// Result beats cannot be stalled; o_busy rises only when the queue is full.
module integer_to_ascii_formatter #(
    parameter int QUEUE_DEPTH = i2a_pkg::I2A_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  i2a_pkg::t_in_item  i_in,
    output logic               o_busy,
    output logic               o_strobe,
    output i2a_pkg::t_out_item o_result
);

    logic             push;
    logic             pop;
    i2a_pkg::t_job    front_job;
    i2a_pkg::t_job    queue_job;
    i2a_pkg::t_q_stat q_stat;

    i2a_front u_front (
        .i_start (i_start),
        .i_in    (i_in),
        .i_stat  (q_stat),
        .o_busy  (o_busy),
        .o_push  (push),
        .o_job   (front_job)
    );

    i2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (q_stat)
    );

    i2a_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (queue_job),
        .i_stat   (q_stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

@@ bench/integer_to_ascii_formatter_tb.sv @@
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

    localparam int CLK_PERIOD_NS = 12;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_VALUES = 400;
    localparam int CALM_VALUES   = 80;
    localparam int DRAIN_CYCLES  = 30;
    localparam int QUIET_LIMIT   = 600;
    localparam int MAX_PRINTED   = 50;

    class char_scoreboard;
        i2a_pkg::t_out_item pending_chars[$];
        int                 mismatches;
        int                 values_seen;
        int                 chars_checked;
        int                 kind_seen [4];

        function void report_mismatch(string msg);
            mismatches++;
            // Keep the log readable if the block goes badly wrong.
            if (mismatches <= MAX_PRINTED) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endfunction

        // Works out the text of one accepted value and queues its characters.
        function void note_value(i2a_pkg::t_in_item item);
            logic [31:0]        mag;
            logic               neg;
            logic [7:0]         text [$];
            string              glyphs;
            i2a_pkg::t_out_item exp_char;
            neg = (item.kind == i2a_pkg::KIND_SDEC) && item.value[31];
            mag = neg ? (~item.value + 32'd1) : item.value;
            if (item.kind == i2a_pkg::KIND_SDEC || item.kind == i2a_pkg::KIND_UDEC) begin
                do begin
                    text.push_front(i2a_pkg::CHAR_ZERO + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end while (mag != 32'd0);
            end else begin
                if (item.kind == i2a_pkg::KIND_HEXL) begin
                    glyphs = "0123456789abcdef";
                end else begin
                    glyphs = "0123456789ABCDEF";
                end
                do begin
                    text.push_front(glyphs[int'(mag[3:0])]);
                    mag = mag >> 4;
                end while (mag != 32'd0);
            end
            if (neg) begin
                text.push_front(i2a_pkg::CHAR_MINUS);
            end
            for (int n = 0; n < text.size(); n++) begin
                exp_char.character  = text[n];
                exp_char.last       = (n == text.size() - 1);
                exp_char.char_count = exp_char.last ? 4'(text.size()) : 4'd0;
                pending_chars.push_back(exp_char);
            end
            values_seen++;
            kind_seen[item.kind]++;
        endfunction

        function void check_char(i2a_pkg::t_out_item got);
            i2a_pkg::t_out_item want;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b count=%0d",
                                          got.character, got.last, got.char_count));
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (got.character !== want.character) begin
                report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                          got.character, want.character));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("last %0b, expected %0b (character 0x%02h)",
                                          got.last, want.last, want.character));
            end
            if (got.char_count !== want.char_count) begin
                report_mismatch($sformatf("char_count %0d, expected %0d (character 0x%02h)",
                                          got.char_count, want.char_count, want.character));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    i2a_pkg::t_in_item  i_in;
    logic               o_busy;
    logic               o_strobe;
    i2a_pkg::t_out_item o_result;

    char_scoreboard sb;
    int             quiet_cycles;

    integer_to_ascii_formatter DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_in     (i_in),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD_NS / 2.0) i_clk = ~i_clk;

    // Beats are taken from the pre-edge values; inputs only move on the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                sb.note_value(i_in);
            end
            if (o_strobe) begin
                sb.check_char(o_result);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_strobe || !i_rst_n) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_value(input logic [1:0] kind, input logic [31:0] value);
        i_start    = 1'b1;
        i_in.kind  = kind;
        i_in.value = value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        i_start = 1'b0;
        repeat (cycles) begin
            i_in = i2a_pkg::t_in_item'({2'($urandom_range(0, 3)), 32'($urandom)});
            @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int unsigned decade;
        case ($urandom_range(0, 6))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 20);
            3: v = 32'($urandom) >> $urandom_range(0, 31);
            4: begin
                // Powers of ten and their neighbors move the digit count.
                decade = 1;
                repeat ($urandom_range(0, 9)) decade = decade * 10;
                v = decade + 32'($urandom_range(0, 2)) - 32'd1;
            end
            5: v = -32'($urandom_range(1, 20));
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h8000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        sb      = new();
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        hold_off(3);

        // Signed decimal edges, including the most negative value.
        send_value(i2a_pkg::KIND_SDEC, 32'd0);
        send_value(i2a_pkg::KIND_SDEC, 32'd1);
        send_value(i2a_pkg::KIND_SDEC, 32'hFFFF_FFFF);
        send_value(i2a_pkg::KIND_SDEC, 32'h7FFF_FFFF);
        send_value(i2a_pkg::KIND_SDEC, 32'h8000_0000);
        send_value(i2a_pkg::KIND_SDEC, -32'd10);
        send_value(i2a_pkg::KIND_SDEC, 32'd9);
        send_value(i2a_pkg::KIND_SDEC, 32'd10);
        hold_off(5);
        send_value(i2a_pkg::KIND_UDEC, 32'd0);
        send_value(i2a_pkg::KIND_UDEC, 32'hFFFF_FFFF);
        send_value(i2a_pkg::KIND_UDEC, 32'h8000_0000);
        send_value(i2a_pkg::KIND_UDEC, 32'd1_000_000_000);
        send_value(i2a_pkg::KIND_UDEC, 32'd999_999_999);
        // Hex in both letter cases, no prefix.
        send_value(i2a_pkg::KIND_HEXL, 32'd0);
        send_value(i2a_pkg::KIND_HEXL, 32'hFFFF_FFFF);
        send_value(i2a_pkg::KIND_HEXL, 32'hDEAD_BEEF);
        send_value(i2a_pkg::KIND_HEXL, 32'h10);
        send_value(i2a_pkg::KIND_HEXL, 32'hF);
        hold_off(2);
        send_value(i2a_pkg::KIND_HEXU, 32'd0);
        send_value(i2a_pkg::KIND_HEXU, 32'hFFFF_FFFF);
        send_value(i2a_pkg::KIND_HEXU, 32'hABCD_EF01);
        send_value(i2a_pkg::KIND_HEXU, 32'h8000_0000);

        for (int n = 0; n < RANDOM_VALUES; n++) begin
            if (n < RANDOM_VALUES - CALM_VALUES && $urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 18));
            end
            send_value(2'($urandom_range(0, 3)), pick_value());
        end
        hold_off(1);

        while (sb.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_chars.size() != 0) begin
            sb.report_mismatch($sformatf("%0d characters never arrived",
                                         sb.pending_chars.size()));
        end

        $display("Formatted %0d values into %0d checked characters, %0d mismatches.",
                 sb.values_seen, sb.chars_checked, sb.mismatches);
        $display("Values per format: signed %0d, unsigned %0d, hex lower %0d, hex upper %0d.",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
